[design/ctrp_pkg.sv]
// Shared types, constants and header decode for the color transform record parser.
`timescale 1ns / 1ps

package ctrp_pkg;

   localparam int RECORD_BYTES = 16;
   localparam int REC_W        = RECORD_BYTES * 8;
   localparam int TERM_W       = 15;
   localparam int IDX_W        = $clog2(RECORD_BYTES);
   localparam int CNT_W        = IDX_W + 1;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int NUM_TERMS    = 8;
   localparam int RSP_W        = 136;

   localparam logic signed [TERM_W-1:0] MULT_DEFAULT = 15'sd256;

   // One byte handed from the front to the back, marked when it closes a record.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } ctrp_word_type;

   // Record length in bytes from the header byte: ceil((6 + 4*n*(add+mult)) / 8).
   function automatic logic [4:0] ctrp_needed(input logic [7:0] hdr);
      logic [1:0] flags;
      logic [7:0] prod;
      logic [7:0] total;
      flags = {1'b0, hdr[7]} + {1'b0, hdr[6]};
      prod  = {2'b00, hdr[5:2], 2'b00} * {6'd0, flags};
      total = prod + 8'd13;
      return total[7:3];
   endfunction

endpackage

[design/ctrp_front.sv]
// Front end: accepts stream words, tracks the record header and marks record ends.
`timescale 1ns / 1ps

module ctrp_front
   import ctrp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,
   input  logic          req_tlast,
   input  logic          q_full,
   output logic          q_push,
   output ctrp_word_type q_word
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       hdr_ff, hdr_in;
   logic [7:0]       hdr;
   logic [4:0]       needed;
   logic [CNT_W-1:0] count_next;
   logic             accept;
   logic             last;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // Classify the word: the first word of a record is its header
   always_comb begin
      hdr        = (count_ff == '0) ? req_tdata : hdr_ff;
      needed     = ctrp_needed(hdr);
      count_next = count_ff + CNT_W'(1);
      last       = (5'(count_next) >= needed) || req_tlast;
   end

   assign q_push = accept;
   assign q_word = '{data: req_tdata, last: last};

   // Advance the byte count, restart it at each record end
   always_comb begin
      count_in = count_ff;
      hdr_in   = hdr_ff;
      if (accept) begin
         count_in = last ? '0 : count_next;
         if (count_ff == '0) begin
            hdr_in = req_tdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      hdr_ff <= hdr_in;
   end

endmodule

[design/ctrp_queue.sv]
// Short word queue between the front end and the back end.
`timescale 1ns / 1ps

module ctrp_queue
   import ctrp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  ctrp_word_type push_word,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output ctrp_word_type head_word
);

   ctrp_word_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full       = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_word  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

[design/ctrp_back.sv]
// Back end: gathers record bytes, extracts the terms and holds the result word.
`timescale 1ns / 1ps

module ctrp_back
   import ctrp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  ctrp_word_type    head_word,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   logic [7:0]       buf_ff [RECORD_BYTES];
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [REC_W-1:0] snap_ff, snap_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             out_valid_ff, out_valid_in;
   logic [RSP_W-1:0] out_data_ff, out_data_in;
   logic             s1_ready, out_ready;

   assign out_ready = !out_valid_ff || rsp_tready;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign pop       = head_valid && s1_ready;

   // Build the record image, first byte on top; bytes not yet received read as zero
   always_comb begin
      snap_in = '0;
      for (int i = 0; i < RECORD_BYTES; i++) begin
         if (IDX_W'(i) < cnt_ff) begin
            snap_in[REC_W-1-8*i -: 8] = buf_ff[i];
         end else if (IDX_W'(i) == cnt_ff) begin
            snap_in[REC_W-1-8*i -: 8] = head_word.data;
         end
      end
   end

   // Advance the byte index, restart it at each record end
   always_comb begin
      cnt_in      = cnt_ff;
      s1_valid_in = s1_valid_ff;
      if (s1_ready) begin
         s1_valid_in = pop && head_word.last;
      end
      if (pop) begin
         cnt_in = head_word.last ? '0 : cnt_ff + IDX_W'(1);
      end
   end

   // Extract the header and the eight terms from the record image
   logic [7:0]                 hdr;
   logic                       has_add, has_mult;
   logic [3:0]                 nbits;
   logic [REC_W+TERM_W-1:0]    ext;
   logic [2:0]                 slot;
   logic [7:0]                 pos;
   logic [7:0]                 base;
   logic [TERM_W-1:0]          window;
   logic signed [TERM_W-1:0]   terms [NUM_TERMS];
   logic [3:0]                 shamt;

   always_comb begin
      hdr      = snap_ff[REC_W-1 -: 8];
      has_add  = hdr[7];
      has_mult = hdr[6];
      nbits    = hdr[5:2];
      ext      = {snap_ff, TERM_W'(0)};
      shamt    = 4'(TERM_W) - nbits;
      for (int j = 0; j < NUM_TERMS; j++) begin
         if (j < 4) begin
            slot = 3'(j);
         end else begin
            slot = 3'(j - 4) + (has_mult ? 3'd4 : 3'd0);
         end
         pos    = 8'd6 + 8'({4'd0, slot} * {3'd0, nbits});
         base   = 8'(REC_W + TERM_W - 1) - pos;
         window = ext[base -: TERM_W];
         if (nbits == 4'd0) begin
            terms[j] = '0;
         end else begin
            terms[j] = $signed(window) >>> shamt;
         end
         if (j < 4 && !has_mult) begin
            terms[j] = MULT_DEFAULT;
         end
         if (j >= 4 && !has_add) begin
            terms[j] = '0;
         end
      end
   end

   // Load the result word when the output side is free
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_ready) begin
         out_valid_in = s1_valid_ff;
         out_data_in  = {5'd0, ctrp_needed(hdr),
                         terms[7], terms[6], terms[5], terms[4],
                         terms[3], terms[2], terms[1], terms[0],
                         nbits, has_mult, has_add};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (pop && !head_word.last) begin
         buf_ff[cnt_ff] <= head_word.data;
      end
      if (s1_ready) begin
         snap_ff <= snap_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

[design/color_transform_record_parser_top.sv]
// Top level of the color transform record parser.
//
// Input stream (req_): one record byte per word in req_tdata; req_tlast marks
// the final byte of the data, after which missing record bits read as zero.
// Result stream (rsp_): one word per record, sent when the record's last byte
// (taken from the header length) or a req_tlast byte has been accepted.
// Absent multiply terms read 256, absent add terms read 0.
// Throughput with rsp_tready high: one input word per cycle; back-to-back
// one-byte records, one result per cycle. The front end decodes the header and
// marks record ends, a four-word queue feeds the back end, which gathers the
// bytes, extracts all eight terms from the record image in one stage and
// holds the result in an output register.
// Result path: the closing byte passes the queue, the record image register
// and the output register before the result shows on rsp_tvalid.
// Reset (synchronous, active high) drops any partial record and any pending
// result. When rsp_tready stays low the output register holds, the back end
// stops draining the queue, and req_tready falls once the queue is full.
`timescale 1ns / 1ps

module color_transform_record_parser_top
   import ctrp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] data_byte
   input  logic             req_tlast,   // end_of_data
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [0] has_add, [1] has_mult, [5:2] term_bits, [20:6] red_mult,
   // [35:21] green_mult, [50:36] blue_mult, [65:51] alpha_mult,
   // [80:66] red_add, [95:81] green_add, [110:96] blue_add,
   // [125:111] alpha_add, [130:126] bytes_used, [135:131] zero
   output logic [RSP_W-1:0] rsp_tdata
);

   logic          q_push, q_full, q_pop, q_valid;
   ctrp_word_type q_word, q_head;

   ctrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_word     (q_word)
   );

   ctrp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_word  (q_word),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_word  (q_head)
   );

   ctrp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_word  (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
